[rtl/tcw_pkg.sv]
package tcw_pkg;

   localparam int COLUMNS_DEFAULT   = 80;
   localparam int ROWS_DEFAULT      = 25;
   localparam int TAB_WIDTH_DEFAULT = 8;

   localparam int CELL_WIDTH = 16;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

   localparam logic [7:0] BLANK_CHAR  = 8'h20;
   localparam logic [7:0] SCROLL_ATTR = 8'h0F;
   localparam logic [3:0] CLEAR_FG    = 4'hF;

   localparam logic [3:0] RESET_BACKGROUND = 4'h0;
   localparam logic [3:0] RESET_FOREGROUND = 4'hF;

   localparam logic [0:0] CSR_BACKGROUND = 1'b0;
   localparam logic [0:0] CSR_FOREGROUND = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_CLEAR,
      ST_FINISH
   } state_type;

endpackage

[rtl/tcw_ram.sv]
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/text_console_writer.sv]
// Put, read and unused commands: the item goes from idle to the finish state, and
// the result is registered there once the result output is not stalled. A put
// that scrolls first copies or blanks one cell per cycle through the single screen
// RAM write port; a clear first blanks every cell. Items are taken one at a time.
// Reset (synchronous, active high) homes the cursor and runs a zero pass over the
// screen RAM (COLUMNS*ROWS cells, 2000 by default) before the first item is taken.
module text_console_writer #(
   parameter int COLUMNS   = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS      = tcw_pkg::ROWS_DEFAULT,
   parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_cursor_position,
   output logic [15:0] rsp_cell_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CLW   = $clog2(COLUMNS);
   localparam int XW    = $clog2(COLUMNS + TAB_WIDTH);
   localparam int RW    = $clog2(ROWS);
   localparam int PW    = $clog2(TAB_WIDTH);
   localparam int CW    = tcw_pkg::CELL_WIDTH;

   localparam logic [AW-1:0] CNT_LAST    = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_CELLS  = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);
   localparam logic [PW-1:0] PHASE_LAST  = PW'(TAB_WIDTH - 1);

   tcw_pkg::state_type state_ff, state_in;

   logic [CLW-1:0] col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [PW-1:0]  phase_ff, phase_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [3:0]     bg_ff, fg_ff;
   logic           rd_ok_ff, rd_ok_in;
   logic           copy_pend_ff;
   logic           pend_blank_ff;
   logic [AW-1:0]  pend_addr_ff;
   logic           rsp_valid_ff;
   logic [10:0]    rsp_pos_ff;
   logic [CW-1:0]  rsp_cell_ff;

   logic           accept;
   logic           rsp_load;
   logic           cnt_last;
   logic [AW-1:0]  cur_pos;

   // put decode
   logic [XW-1:0]  put_col_x;
   logic [RW:0]    put_row_x;
   logic [PW-1:0]  put_phase;
   logic           put_we;
   logic           put_scroll;
   logic [CLW-1:0] put_col;
   logic [RW-1:0]  put_row;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [CW-1:0]  ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [CW-1:0]  ram_rdata;

   assign accept    = req_valid && !req_stall;
   assign cnt_last  = (cnt_ff == CNT_LAST);
   assign cur_pos   = AW'(row_ff) * ROW_STRIDE + AW'(col_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      put_col_x  = XW'(col_ff);
      put_row_x  = (RW+1)'(row_ff);
      put_phase  = phase_ff;
      put_we     = 1'b0;
      put_scroll = 1'b0;
      case (req_char_code)
         tcw_pkg::CH_BACKSPACE: begin
            if (col_ff != '0) begin
               put_col_x = XW'(col_ff) - XW'(1);
               put_phase = (phase_ff == '0) ? PHASE_LAST : phase_ff - PW'(1);
            end
         end
         tcw_pkg::CH_TAB: begin
            put_col_x = XW'(col_ff) + XW'(TAB_WIDTH) - XW'(phase_ff);
            put_phase = '0;
         end
         tcw_pkg::CH_RETURN: begin
            put_col_x = '0;
            put_phase = '0;
         end
         tcw_pkg::CH_NEWLINE: begin
            put_col_x = '0;
            put_phase = '0;
            put_row_x = (RW+1)'(row_ff) + (RW+1)'(1);
         end
         default: begin
            if (req_char_code inside {[tcw_pkg::CH_PRINT_LO:tcw_pkg::CH_PRINT_HI]}) begin
               put_we    = 1'b1;
               put_col_x = XW'(col_ff) + XW'(1);
               put_phase = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PW'(1);
            end
         end
      endcase
      // wrap past the last column
      if (put_col_x >= XW'(COLUMNS)) begin
         put_col_x = '0;
         put_phase = '0;
         put_row_x = put_row_x + (RW+1)'(1);
      end
      if (put_row_x >= (RW+1)'(ROWS)) begin
         put_scroll = 1'b1;
         put_row_x  = (RW+1)'(ROWS - 1);
      end
      put_col = CLW'(put_col_x);
      put_row = RW'(put_row_x);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (cnt_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == tcw_pkg::CMD_CLEAR) begin
                  state_in = tcw_pkg::ST_CLEAR;
               end else if (req_cmd == tcw_pkg::CMD_PUT && put_scroll) begin
                  state_in = tcw_pkg::ST_SCROLL;
               end else begin
                  state_in = tcw_pkg::ST_FINISH;
               end
            end
         end
         tcw_pkg::ST_SCROLL, tcw_pkg::ST_CLEAR: begin
            if (cnt_last) begin
               state_in = tcw_pkg::ST_FINISH;
            end
         end
         tcw_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_INIT;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall = (state_ff != tcw_pkg::ST_IDLE);
      rsp_load  = (state_ff == tcw_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = fill_ff;
      ram_re    = 1'b0;
      ram_raddr = AW'(req_cell_index);
      col_in    = col_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff + AW'(1);
      fill_in   = fill_ff;
      rd_ok_in  = rd_ok_ff;
      case (state_ff)
         tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
         end
         tcw_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               rd_ok_in = 1'b0;
               case (req_cmd)
                  tcw_pkg::CMD_PUT: begin
                     ram_we    = put_we;
                     ram_waddr = cur_pos;
                     ram_wdata = {bg_ff, fg_ff, req_char_code};
                     col_in    = put_col;
                     row_in    = put_row;
                     phase_in  = put_phase;
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     fill_in  = {bg_ff, tcw_pkg::CLEAR_FG, tcw_pkg::BLANK_CHAR};
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                  end
                  tcw_pkg::CMD_READ: begin
                     ram_re   = 1'b1;
                     rd_ok_in = (32'(req_cell_index) < 32'(CELLS));
                  end
                  default: ;
               endcase
            end
         end
         tcw_pkg::ST_SCROLL: begin
            // fetch the cell one row below; the registered read data is written back to the current cell
            ram_re    = (cnt_ff < COPY_CELLS);
            ram_raddr = cnt_ff + ROW_STRIDE;
         end
         default: ;
      endcase
      if (copy_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = pend_blank_ff ? {tcw_pkg::SCROLL_ATTR, tcw_pkg::BLANK_CHAR} : ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         rd_ok_ff     <= 1'b0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bg_ff        <= tcw_pkg::RESET_BACKGROUND;
         fg_ff        <= tcw_pkg::RESET_FOREGROUND;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rd_ok_ff     <= rd_ok_in;
         copy_pend_ff <= (state_ff == tcw_pkg::ST_SCROLL);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == tcw_pkg::CSR_BACKGROUND) begin
               bg_ff <= csr_data;
            end else begin
               fg_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= cnt_ff;
      pend_blank_ff <= (cnt_ff >= COPY_CELLS);
      if (rsp_load) begin
         rsp_pos_ff  <= 11'(cur_pos);
         rsp_cell_ff <= rd_ok_ff ? ram_rdata : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_value      = rsp_cell_ff;

   tcw_ram #(
      .WIDTH (CW),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor outside the screen");

   a_phase_tracks_col: assert property (@(posedge clock) disable iff (reset)
      32'(phase_ff) < 32'(TAB_WIDTH))
      else $error("tab phase out of range");

   a_copy_window: assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> (state_ff == tcw_pkg::ST_SCROLL || state_ff == tcw_pkg::ST_FINISH))
      else $error("scroll write pending outside the scroll pass");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tcw_pkg::ST_FINISH)
      else $error("result raised outside finish");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != tcw_pkg::ST_IDLE)
      else $error("accepted item did not leave idle");

endmodule

[dv/text_console_writer_tb.sv]
module text_console_writer_tb;

   localparam int COLUMNS     = tcw_pkg::COLUMNS_DEFAULT;
   localparam int ROWS        = tcw_pkg::ROWS_DEFAULT;
   localparam int TAB_WIDTH   = tcw_pkg::TAB_WIDTH_DEFAULT;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int DRAIN_CYCLES = 50;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } console_item_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [15:0] cell_value;
   } console_result_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd        = '0;
   logic [7:0]  req_char_code  = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [10:0] rsp_cursor_position;
   logic [15:0] rsp_cell_value;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index      = '0;
   logic [3:0]  csr_data       = '0;

   // screen and cursor as the block should hold them
   logic [15:0] screen_model [CELL_COUNT];
   int          cursor_col;
   int          cursor_row;
   logic [3:0]  background;
   logic [3:0]  foreground;

   console_item_type   pending_items [$];
   console_result_type expected_results [$];
   int   items_queued   = 0;
   int   items_accepted = 0;
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   send_idle_pct  = 0;
   int   recv_idle_pct  = 0;
   logic req_taken      = 1'b0;

   text_console_writer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_value      (rsp_cell_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic predict_console_item(input console_item_type it);
      console_result_type res;
      logic [15:0]        cell_word;
      int                 i;
      cell_word = '0;
      case (it.cmd)
         tcw_pkg::CMD_PUT: begin
            if (it.char_code == tcw_pkg::CH_BACKSPACE) begin
               if (cursor_col != 0) cursor_col--;
            end else if (it.char_code == tcw_pkg::CH_TAB) begin
               cursor_col = cursor_col + TAB_WIDTH - (cursor_col % TAB_WIDTH);
            end else if (it.char_code == tcw_pkg::CH_RETURN) begin
               cursor_col = 0;
            end else if (it.char_code == tcw_pkg::CH_NEWLINE) begin
               cursor_col = 0;
               cursor_row++;
            end else if (it.char_code >= tcw_pkg::CH_PRINT_LO &&
                         it.char_code <= tcw_pkg::CH_PRINT_HI) begin
               screen_model[cursor_row * COLUMNS + cursor_col] =
                  {background, foreground, it.char_code};
               cursor_col++;
            end
            if (cursor_col >= COLUMNS) begin
               cursor_col = 0;
               cursor_row++;
            end
            // scroll up one row, blank the bottom row
            if (cursor_row >= ROWS) begin
               for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                  screen_model[i] = screen_model[i + COLUMNS];
               for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                  screen_model[i] = {tcw_pkg::SCROLL_ATTR, tcw_pkg::BLANK_CHAR};
               cursor_row = ROWS - 1;
            end
         end
         tcw_pkg::CMD_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++)
               screen_model[i] = {background, tcw_pkg::CLEAR_FG, tcw_pkg::BLANK_CHAR};
            cursor_col = 0;
            cursor_row = 0;
         end
         tcw_pkg::CMD_READ: begin
            if (it.cell_index < CELL_COUNT) cell_word = screen_model[it.cell_index];
         end
         default: ;
      endcase
      res.cursor_position = 11'(cursor_row * COLUMNS + cursor_col);
      res.cell_value      = cell_word;
      expected_results.push_back(res);
   endtask

   function automatic console_item_type random_console_item();
      console_item_type it;
      int               pick;
      it.cmd        = tcw_pkg::CMD_PUT;
      it.char_code  = 8'($urandom);
      it.cell_index = 11'($urandom);
      pick = $urandom_range(999);
      if (pick < 600) begin
         it.char_code = 8'($urandom_range(tcw_pkg::CH_PRINT_HI, tcw_pkg::CH_PRINT_LO));
      end else if (pick < 650) begin
         it.char_code = tcw_pkg::CH_NEWLINE;
      end else if (pick < 700) begin
         it.char_code = tcw_pkg::CH_TAB;
      end else if (pick < 730) begin
         it.char_code = tcw_pkg::CH_RETURN;
      end else if (pick < 770) begin
         it.char_code = tcw_pkg::CH_BACKSPACE;
      end else if (pick < 820) begin
         // any byte, ignored ones included
      end else if (pick < 960) begin
         it.cmd = tcw_pkg::CMD_READ;
         case ($urandom_range(2))
            0: it.cell_index = 11'($urandom_range(CELL_COUNT - 1));
            // text piles up at the bottom after scrolling
            1: it.cell_index = 11'($urandom_range(CELL_COUNT - 1, (ROWS - 6) * COLUMNS));
            default: ;
         endcase
      end else if (pick < 985) begin
         it.cmd = CMD_UNUSED;
      end else begin
         it.cmd = tcw_pkg::CMD_CLEAR;
      end
      return it;
   endfunction

   task automatic queue_item(input logic [1:0] cmd, input logic [7:0] char_code,
                             input logic [10:0] cell_index);
      pending_items.push_back('{cmd, char_code, cell_index});
      items_queued++;
   endtask

   task automatic queue_random_items(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         pending_items.push_back(random_console_item());
         items_queued++;
      end
   endtask

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || items_accepted != items_queued ||
             expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_colour(input logic [0:0] index, input logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == tcw_pkg::CSR_BACKGROUND) background = value;
      else foreground = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drive at the falling edge; hold a stalled item
   always @(negedge clock) begin
      console_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item      = pending_items.pop_front();
            req_valid      <= 1'b1;
            req_cmd        <= next_item.cmd;
            req_char_code  <= next_item.char_code;
            req_cell_index <= next_item.cell_index;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      console_result_type want;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual cursor %0d cell %h",
                     $time, rsp_cursor_position, rsp_cell_value);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_cursor_position !== want.cursor_position) begin
               $display("%0t: cursor_position expected %0d actual %0d",
                        $time, want.cursor_position, rsp_cursor_position);
               mismatch_count++;
            end
            if (rsp_cell_value !== want.cell_value) begin
               $display("%0t: cell_value expected %h actual %h",
                        $time, want.cell_value, rsp_cell_value);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         predict_console_item('{req_cmd, req_char_code, req_cell_index});
         items_accepted++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d items still expected", $time, expected_results.size());
         $display("text_console_writer: mismatch");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < CELL_COUNT; i++) screen_model[i] = '0;
      cursor_col = 0;
      cursor_row = 0;
      background = tcw_pkg::RESET_BACKGROUND;
      foreground = tcw_pkg::RESET_FOREGROUND;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 47;
      write_colour(tcw_pkg::CSR_BACKGROUND, 4'hF);
      write_colour(tcw_pkg::CSR_FOREGROUND, 4'h0);

      queue_item(tcw_pkg::CMD_READ, 8'h00, 11'd0);
      queue_item(tcw_pkg::CMD_READ, 8'hFF, 11'd1999);
      queue_item(tcw_pkg::CMD_READ, 8'h00, 11'd2000);
      queue_item(tcw_pkg::CMD_READ, 8'hFF, 11'd2047);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 11'd2047);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_PRINT_LO, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_PRINT_HI, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, 8'h00, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, 8'h1F, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, 8'h80, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, 8'hFF, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
      queue_item(tcw_pkg::CMD_READ, 8'h00, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_RETURN, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
      queue_item(CMD_UNUSED, 8'hFF, 11'd2047);
      queue_item(tcw_pkg::CMD_READ, 8'h00, 11'd1);
      queue_item(tcw_pkg::CMD_CLEAR, 8'h00, 11'd0);
      queue_item(tcw_pkg::CMD_READ, 8'h00, 11'd1999);
      queue_item(tcw_pkg::CMD_PUT, 8'h41, 11'd0);
      queue_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
      queue_random_items(340);
      wait_until_drained();

      send_idle_pct = 47;
      recv_idle_pct = 38;
      write_colour(tcw_pkg::CSR_BACKGROUND, 4'h0);
      write_colour(tcw_pkg::CSR_FOREGROUND, 4'hF);
      queue_random_items(370);
      wait_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_colour(tcw_pkg::CSR_BACKGROUND, 4'($urandom));
      write_colour(tcw_pkg::CSR_FOREGROUND, 4'($urandom));
      queue_random_items(370);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("text_console_writer: match");
      else
         $display("text_console_writer: mismatch");
      $finish;
   end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
dv/text_console_writer_tb.sv
